@@ src/xml_sax_tokenizer_assert.svh @@
// Assertion macros shared by the tokenizer modules.
`ifndef XML_SAX_TOKENIZER_ASSERT_SVH
`define XML_SAX_TOKENIZER_ASSERT_SVH
// Property that holds after the antecedent in the same cycle.
`define XST_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) \
    else $error("assertion failed");
// Property that holds in the cycle after the antecedent.
`define XST_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/xst_pkg.sv @@
// -----------------------------------------------------------------------------
// xst_pkg
// Shared types and codes of the XML tokenizer.
// -----------------------------------------------------------------------------
package xst_pkg;
  localparam int unsigned OffsetBits  = 32;
  localparam int unsigned BalanceBits = 16;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [2:0] EvDocStart = 3'd0;
  localparam logic [2:0] EvText     = 3'd1;
  localparam logic [2:0] EvSpace    = 3'd2;
  localparam logic [2:0] EvEStart   = 3'd3;
  localparam logic [2:0] EvEEnd     = 3'd4;
  localparam logic [2:0] EvAttr     = 3'd5;
  localparam logic [2:0] EvError    = 3'd6;
  localparam logic [2:0] EvDocEnd   = 3'd7;

  localparam logic [1:0] ErrEmptyTag  = 2'd0;
  localparam logic [1:0] ErrEndSpace  = 2'd1;
  localparam logic [1:0] ErrEmptyAttr = 2'd2;
  localparam logic [1:0] ErrUnbal     = 2'd3;

  // One result event.
  typedef struct packed {
    logic [2:0]  ev;
    logic [1:0]  err;
    logic [31:0] sb;
    logic [31:0] se;
    logic        hv;
    logic [31:0] vb;
    logic [31:0] ve;
  } event_t;

  // Up to four events caused by one input item.
  typedef struct packed {
    logic [2:0] cnt;
    event_t [3:0] evs;
  } group_t;
endpackage

@@ src/xst_front.sv @@
// -----------------------------------------------------------------------------
// xst_front
// Tag state machine: one byte per cycle when step_i is set; builds event groups.
// -----------------------------------------------------------------------------
module xst_front #(
  parameter int unsigned OffsetBits  = xst_pkg::OffsetBits,
  parameter int unsigned BalanceBits = xst_pkg::BalanceBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            mode_i,
  input  logic [7:0]      byte_in_i,
  output xst_pkg::group_t group_o
);
  localparam logic [2:0] StCdata = 3'd0;
  localparam logic [2:0] StMod   = 3'd1;
  localparam logic [2:0] StName  = 3'd2;
  localparam logic [2:0] StOpen  = 3'd3;
  localparam logic [2:0] StAttr  = 3'd4;
  localparam logic [2:0] StQuote = 3'd5;
  localparam logic [2:0] StIgn   = 3'd6;
  localparam logic [OffsetBits-1:0]  OffMax = '1;
  localparam logic [BalanceBits-1:0] BalMax = '1;
  localparam logic [7:0] ChLt = 8'h3c, ChGt = 8'h3e, ChSl = 8'h2f, ChEq = 8'h3d;
  localparam logic [7:0] ChEx = 8'h21, ChQm = 8'h3f, ChDq = 8'h22, ChSq = 8'h27;

  typedef logic [OffsetBits-1:0] off_t;

  logic [2:0] state_q, state_d;
  off_t pos_q, pos_d, ts_q, ts_d, nf_q, nf_d, nl_q, nl_d, af_q, af_d, eqp_q, eqp_d;
  logic [7:0] oq_q, oq_d, bae_q, bae_d, pb_q, pb_d;
  logic fe_q, fe_d, fend_q, fend_d, fa_q, fa_d, fdoc_q, fdoc_d;
  logic sp_q, sp_d, eqpend_q, eqpend_d, anul_q, anul_d;
  logic [BalanceBits-1:0] oc_q, oc_d;
  xst_pkg::group_t g;

  function automatic off_t sat_inc(input off_t x);
    return (x == OffMax) ? x : x + off_t'(1);
  endfunction

  function automatic logic [31:0] lo32(input off_t x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  function automatic logic is_sp(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Step logic: next state and this byte's events, or end of document on mode_i.
  always_comb begin
    logic [7:0] c, bq;
    off_t n, vb, vq;
    logic fin_attr, fin_tag, ent_cd;
    c = byte_in_i;
    bq = bae_q;
    n = pos_q;
    vb = sat_inc(eqp_q);
    vq = sat_inc(vb);
    fin_attr = 1'b0;
    fin_tag = 1'b0;
    ent_cd = 1'b0;
    state_d = state_q; pos_d = pos_q; ts_d = ts_q; nf_d = nf_q; nl_d = nl_q;
    af_d = af_q; eqp_d = eqp_q; oq_d = oq_q; bae_d = bae_q; pb_d = pb_q;
    fe_d = fe_q; fend_d = fend_q; fa_d = fa_q; fdoc_d = fdoc_q; sp_d = sp_q;
    eqpend_d = eqpend_q; anul_d = anul_q; oc_d = oc_q;
    g = '0;
    if (mode_i) begin
      if (oc_q != '0) begin
        g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvError, err: xst_pkg::ErrUnbal,
                             sb: lo32(n), se: lo32(n), default: '0};
        g.cnt = g.cnt + 3'd1;
      end
      if (fdoc_q) begin
        g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvDocEnd, default: '0};
        g.cnt = g.cnt + 3'd1;
      end
      state_d = StCdata; pos_d = '0; ts_d = '0; nf_d = '0; nl_d = '0; af_d = '0;
      eqp_d = '0; oq_d = '0; bae_d = '0; pb_d = '0; fe_d = 1'b0; fend_d = 1'b0;
      fa_d = 1'b0; fdoc_d = 1'b0; sp_d = 1'b1; eqpend_d = 1'b0; anul_d = 1'b0;
      oc_d = '0;
    end else begin
      if (eqpend_q) begin
        bq = c;
        bae_d = c;
        eqpend_d = 1'b0;
      end
      case (state_q)
        StMod: begin
          if (c == ChEx || c == ChQm) begin
            if (oc_q != '0) oc_d = oc_q - 1'b1;
            state_d = StIgn;
          end else if (c == ChGt) begin
            g.evs[0] = '{ev: xst_pkg::EvError, err: xst_pkg::ErrEmptyTag,
                        sb: lo32(n), se: lo32(n), default: '0};
            g.cnt = 3'd1;
            ent_cd = 1'b1;
          end else if (c == ChSl) begin
            fend_d = 1'b1;
          end else begin
            nf_d = n;
            state_d = StName;
          end
        end
        StName: begin
          if (is_sp(c)) begin
            if (fend_q) begin
              g.evs[0] = '{ev: xst_pkg::EvError, err: xst_pkg::ErrEndSpace,
                          sb: lo32(n), se: lo32(n), default: '0};
              g.cnt = 3'd1;
            end
            nl_d = n;
            state_d = StOpen;
          end else if (c == ChGt) begin
            nl_d = n;
            fin_tag = 1'b1;
            ent_cd = 1'b1;
          end
        end
        StOpen: begin
          if (c == ChGt) begin
            fin_tag = 1'b1;
            ent_cd = 1'b1;
          end else if (c == ChSl) begin
            fe_d = 1'b1;
          end else if (!is_sp(c)) begin
            af_d = n;
            if (c == ChDq || c == ChSq) begin
              oq_d = c;
              anul_d = 1'b0;
              state_d = StQuote;
            end else begin
              anul_d = (c == 8'h00);
              fa_d = 1'b1;
              state_d = StAttr;
            end
          end
        end
        StAttr: begin
          if (c == ChGt) begin
            fin_attr = 1'b1;
            fin_tag = 1'b1;
            ent_cd = 1'b1;
          end else if (c == ChEq) begin
            eqp_d = n;
            eqpend_d = 1'b1;
          end else if (c == ChDq || c == ChSq) begin
            oq_d = c;
            state_d = StQuote;
          end else if (is_sp(c)) begin
            fin_attr = 1'b1;
            state_d = StOpen;
          end
        end
        StQuote: begin
          if ((c == ChDq || c == ChSq) && c == oq_q) state_d = StAttr;
        end
        StIgn: begin
          if (c == ChGt) ent_cd = 1'b1;
        end
        default: begin
          if (c == ChLt) begin
            if (!fdoc_q) begin
              fdoc_d = 1'b1;
              g.evs[0] = '{ev: xst_pkg::EvDocStart, default: '0};
              g.cnt = 3'd1;
            end
            fe_d = 1'b0;
            fend_d = 1'b0;
            if (n > ts_q) begin
              g.evs[g.cnt[1:0]] = '{ev: sp_q ? xst_pkg::EvSpace : xst_pkg::EvText,
                                   sb: lo32(ts_q), se: lo32(n), default: '0};
              g.cnt = g.cnt + 3'd1;
            end
            state_d = StMod;
            if (oc_q != BalMax) oc_d = oc_q + 1'b1;
          end else if (!is_sp(c)) begin
            sp_d = 1'b0;
          end
        end
      endcase
      // Attribute completion.
      if (fin_attr && fa_q) begin
        if (anul_q) begin
          g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvError, err: xst_pkg::ErrEmptyAttr,
                               sb: lo32(af_q), se: lo32(af_q), default: '0};
          g.cnt = g.cnt + 3'd1;
        end
        if (eqp_q > af_q) begin
          if ((bq == ChDq || bq == ChSq) && pb_q == bq && n != '0 &&
              vq <= n - off_t'(1))
            g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvAttr, err: '0, sb: lo32(af_q),
                                 se: lo32(eqp_q), hv: 1'b1, vb: lo32(vq),
                                 ve: lo32(n - off_t'(1))};
          else
            g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvAttr, err: '0, sb: lo32(af_q),
                                 se: lo32(eqp_q), hv: 1'b1, vb: lo32(vb),
                                 ve: lo32(n)};
        end else begin
          g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvAttr, sb: lo32(af_q), se: lo32(n),
                               default: '0};
        end
        g.cnt = g.cnt + 3'd1;
        fa_d = 1'b0;
      end
      // Element completion; the name end is this byte when a name ends on '>'.
      if (fin_tag) begin
        if (!fend_q) begin
          g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvEStart, sb: lo32(nf_q),
                               se: lo32(nl_d), default: '0};
          g.cnt = g.cnt + 3'd1;
          if (fe_q) begin
            g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvEEnd, sb: lo32(nf_q),
                                 se: lo32(nl_d), default: '0};
            g.cnt = g.cnt + 3'd1;
          end
        end else begin
          g.evs[g.cnt[1:0]] = '{ev: xst_pkg::EvEEnd, sb: lo32(nf_q),
                               se: lo32(nl_d), default: '0};
          g.cnt = g.cnt + 3'd1;
        end
        if (oc_q != '0) oc_d = oc_q - 1'b1;
      end
      if (ent_cd) begin
        state_d = StCdata;
        ts_d = sat_inc(n);
        sp_d = 1'b1;
      end
      pb_d = c;
      pos_d = sat_inc(n);
    end
  end

  assign group_o = g;

  // State registers advance on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCdata; pos_q <= '0; ts_q <= '0; nf_q <= '0; nl_q <= '0;
      af_q <= '0; eqp_q <= '0; oq_q <= '0; bae_q <= '0; pb_q <= '0;
      fe_q <= 1'b0; fend_q <= 1'b0; fa_q <= 1'b0; fdoc_q <= 1'b0; sp_q <= 1'b1;
      eqpend_q <= 1'b0; anul_q <= 1'b0; oc_q <= '0;
    end else if (step_i) begin
      state_q <= state_d; pos_q <= pos_d; ts_q <= ts_d; nf_q <= nf_d; nl_q <= nl_d;
      af_q <= af_d; eqp_q <= eqp_d; oq_q <= oq_d; bae_q <= bae_d; pb_q <= pb_d;
      fe_q <= fe_d; fend_q <= fend_d; fa_q <= fa_d; fdoc_q <= fdoc_d; sp_q <= sp_d;
      eqpend_q <= eqpend_d; anul_q <= anul_d; oc_q <= oc_d;
    end
  end

`include "xml_sax_tokenizer_assert.svh"
  `XST_ASSERT_IMPL(a_state_legal, clk_i, rst_ni, 1'b1, state_q != 3'd7)
  `XST_ASSERT_NEXT(a_eod_resets, clk_i, rst_ni, step_i && mode_i,
                   state_q == StCdata && pos_q == '0 && oc_q == '0)
  `XST_ASSERT_IMPL(a_group_small, clk_i, rst_ni, 1'b1, g.cnt <= 3'd4)
endmodule

@@ src/xst_back.sv @@
// -----------------------------------------------------------------------------
// xst_back
// Group queue and serializer: sends the events of each group in order.
// -----------------------------------------------------------------------------
module xst_back #(
  parameter int unsigned QueueDepth = xst_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xst_pkg::group_t group_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output xst_pkg::event_t ev_o,
  output logic            last_o
);
  localparam int unsigned Aw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  xst_pkg::group_t mem_q [QueueDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic [1:0]    idx_q;
  xst_pkg::group_t head;
  logic pop, do_push, wrap_w, wrap_r;

  assign head     = mem_q[rp_q];
  assign do_push  = push_i && (group_i.cnt != 3'd0);
  assign out_valid_o = (cnt_q != '0);
  assign ev_o     = head.evs[idx_q];
  assign last_o   = ({1'b0, idx_q} == head.cnt - 3'd1);
  assign pop      = out_valid_o && out_ready_i && last_o;
  assign space_o  = (cnt_q != (Aw+1)'(QueueDepth));
  assign wrap_w   = (wp_q == Aw'(QueueDepth - 1));
  assign wrap_r   = (rp_q == Aw'(QueueDepth - 1));

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= group_i;
  end

  // Pointers, fill count and event index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (do_push) wp_q <= wrap_w ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= wrap_r ? '0 : rp_q + 1'b1;
      if (do_push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && pop) cnt_q <= cnt_q - 1'b1;
      if (out_valid_o && out_ready_i) idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

`include "xml_sax_tokenizer_assert.svh"
  `XST_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, do_push, space_o || pop)
  `XST_ASSERT_IMPL(a_idx_zero_empty, clk_i, rst_ni, cnt_q == '0, idx_q == 2'd0)
  `XST_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= (Aw+1)'(QueueDepth))
endmodule

@@ src/xml_sax_tokenizer.sv @@
// Output: accepted events wait in the event queue behind earlier groups.
// Throughput: one byte per cycle while the event queue has room; a group's
// events leave the output port one at a time, so dense tags may throttle input.
// Reset: asynchronous active low, returns the tag machine to character data,
// offset zero, and empties the event queue.
// -----------------------------------------------------------------------------
// xml_sax_tokenizer
// Streaming XML tokenizer producing span events.
// -----------------------------------------------------------------------------
module xml_sax_tokenizer #(
  parameter int unsigned OffsetBits  = xst_pkg::OffsetBits,
  parameter int unsigned BalanceBits = xst_pkg::BalanceBits,
  parameter int unsigned QueueDepth  = xst_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] span_begin_o,
  output logic [31:0] span_end_o,
  output logic        has_value_o,
  output logic [31:0] value_begin_o,
  output logic [31:0] value_end_o,
  output logic        last_o
);
  xst_pkg::group_t grp;
  xst_pkg::event_t ev;
  logic space, step;

  assign in_ready_o = space;
  assign step = in_valid_i && space;

  xst_front #(.OffsetBits(OffsetBits), .BalanceBits(BalanceBits)) u_front (
    .clk_i, .rst_ni, .step_i(step), .mode_i, .byte_in_i, .group_o(grp)
  );

  xst_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .push_i(step), .group_i(grp), .space_o(space),
    .out_valid_o, .out_ready_i, .ev_o(ev), .last_o
  );

  assign event_res_o   = ev.ev;
  assign error_code_o  = ev.err;
  assign span_begin_o  = ev.sb;
  assign span_end_o    = ev.se;
  assign has_value_o   = ev.hv;
  assign value_begin_o = ev.vb;
  assign value_end_o   = ev.ve;
endmodule
